/* hdl/cfg_branch_region_reachability_macros.svh */
// Assertion macros for the branch region reachability block.
`ifndef CFG_BRANCH_REGION_REACHABILITY_MACROS_SVH
`define CFG_BRANCH_REGION_REACHABILITY_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define CBRR_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define CBRR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CBRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/cbrr_pkg.sv */
// Types and codes shared by the branch region reachability block.
`timescale 1ns / 1ps

package cbrr_pkg;

	// Request codes
	localparam logic [1:0] REQ_LOAD     = 2'd0;
	localparam logic [1:0] REQ_REGION   = 2'd1;
	localparam logic [1:0] REQ_INCOMING = 2'd2;

	// One block table entry, 25 bits
	typedef struct packed {
		logic       has_true;
		logic [7:0] true_succ;
		logic       has_false;
		logic [7:0] false_succ;
		logic       has_match;
		logic [5:0] slot;
	} entry_t;

	// Sequencer states
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CASE  = 8'b0000_0010,
		S_WINIT = 8'b0000_0100,
		S_POP   = 8'b0000_1000,
		S_POPW  = 8'b0001_0000,
		S_EXP0  = 8'b0010_0000,
		S_EXP1  = 8'b0100_0000,
		S_SCAN  = 8'b1000_0000
	} state_t;

endpackage

/* hdl/cfg_branch_region_reachability.sv */
// Top level: block table, depth-first region walker and predecessor scan.
`timescale 1ns / 1ps
`include "cfg_branch_region_reachability_macros.svh"

// Keeps a table of control-flow blocks in a single-port synchronous memory and answers
// three requests, started by a start pulse while busy is low. A load, an unknown request
// or a request rejected on its arguments returns its result in the next cycle and busy
// never rises. A region query reads the case block, then walks twice (from the true and
// from the false successor); each walk pops blocks from the stack, and for each block
// popped it reads the stack, then the table, then examines each successor edge.
// An incoming query scans the table one entry per cycle from index 0 until it finds a
// match or passes the last of the n effective blocks.
// Each result appears for exactly one cycle with done high; there is no way to stall it,
// so the receiver must take every beat. A new request may start in the cycle that done
// shows. The configuration write channel is always ready and should only be used while
// the block is idle.
module cfg_branch_region_reachability
	import cbrr_pkg::*;
#(
	parameter int MAX_BLOCKS = 256,
	parameter int MAX_INSTS  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] cfg_data,
	// request
	input  logic       start,
	output logic       busy,
	input  logic [1:0] req_type,
	input  logic [7:0] block_id,
	input  logic [7:0] target_blk,
	input  logic       has_true,
	input  logic [7:0] true_succ,
	input  logic       has_false,
	input  logic [7:0] false_succ,
	input  logic       has_match_branch,
	input  logic [5:0] match_branch_slot,
	// result
	output logic       done,
	output logic       status,
	output logic       region_contains,
	output logic       found,
	output logic [7:0] pred_block,
	output logic [5:0] branch_slot
);

	localparam int DEPTH = (MAX_BLOCKS < 256) ? MAX_BLOCKS : 256;
	localparam int AW    = $clog2(DEPTH);
	localparam int SPW   = AW + 1;
	localparam int NCAP  = (MAX_BLOCKS < 511) ? MAX_BLOCKS : 511;

	// Control registers
	state_t           state_q, state_d;
	logic [SPW-1:0]   sp_q, sp_d;
	logic             phase_q, phase_d;
	logic [DEPTH-1:0] visited_q;
	logic             done_q;
	logic [8:0]       n_q;

	// Payload registers
	logic [7:0] bid_q, tid_q, start_q, fsucc_q, idx_q;
	logic       rt_q;
	logic       status_q, contains_q, found_q;
	logic [7:0] pred_q;
	logic [5:0] slot_q;

	// Memories
	entry_t     tbl_mem [DEPTH];
	entry_t     tbl_rdata_q;
	logic [7:0] stk_mem [DEPTH];
	logic [7:0] stk_rdata_q;

	// Memory controls
	logic          tbl_we, tbl_re;
	logic [AW-1:0] tbl_waddr, tbl_raddr;
	entry_t        tbl_wdata;
	logic          stk_we, stk_re;
	logic [AW-1:0] stk_waddr, stk_raddr;
	logic [7:0]    stk_wdata;

	// Sequencer outputs
	logic          vis_clr, vis_set;
	logic [AW-1:0] vis_idx;
	logic          walk_done, walk_hit, case_ok, scan_adv;
	logic          emit, emit_status, emit_contains, emit_found;
	logic [7:0]    emit_pred;
	logic [5:0]    emit_slot;

	// Helpers
	logic           accept;
	logic           bid_ok, tid_ok, start_ok, slot_ok;
	logic           succ_has, succ_ok;
	logic [7:0]     succ;
	logic [SPW-1:0] sp_m1;
	logic [8:0]     idx_nxt;
	logic           scan_hit, scan_more;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign bid_ok   = ({1'b0, block_id} < n_q);
	assign tid_ok   = ({1'b0, target_blk} < n_q);
	assign start_ok = ({1'b0, start_q} < n_q);
	assign slot_ok  = has_match_branch && ({7'b0, match_branch_slot} < 13'(MAX_INSTS));

	// Entry written on a load; slot dropped when out of range
	assign tbl_wdata = '{
		has_true:   has_true,
		true_succ:  true_succ,
		has_false:  has_false,
		false_succ: false_succ,
		has_match:  slot_ok,
		slot:       slot_ok ? match_branch_slot : 6'd0
	};

	// Successor under examination: true edge first, then false edge
	assign succ_has = (state_q == S_EXP0) ? tbl_rdata_q.has_true : tbl_rdata_q.has_false;
	assign succ     = (state_q == S_EXP0) ? tbl_rdata_q.true_succ : tbl_rdata_q.false_succ;
	assign succ_ok  = succ_has && ({1'b0, succ} < n_q);
	assign sp_m1    = sp_q - SPW'(1);

	// Predecessor scan
	assign idx_nxt   = {1'b0, idx_q} + 9'd1;
	assign scan_more = (idx_nxt < n_q);
	assign scan_hit  = tbl_rdata_q.has_true && (tbl_rdata_q.true_succ == bid_q)
		&& tbl_rdata_q.has_match;

	// Sequencer
	always_comb begin
		state_d       = state_q;
		sp_d          = sp_q;
		phase_d       = phase_q;
		vis_clr       = 1'b0;
		vis_set       = 1'b0;
		vis_idx       = '0;
		stk_we        = 1'b0;
		stk_waddr     = '0;
		stk_wdata     = '0;
		stk_re        = 1'b0;
		stk_raddr     = '0;
		tbl_we        = 1'b0;
		tbl_waddr     = '0;
		tbl_re        = 1'b0;
		tbl_raddr     = '0;
		walk_done     = 1'b0;
		walk_hit      = 1'b0;
		case_ok       = 1'b0;
		scan_adv      = 1'b0;
		emit          = 1'b0;
		emit_status   = 1'b0;
		emit_contains = 1'b0;
		emit_found    = 1'b0;
		emit_pred     = '0;
		emit_slot     = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_LOAD: begin
							emit = 1'b1;
							if (bid_ok) begin
								tbl_we    = 1'b1;
								tbl_waddr = block_id[AW-1:0];
							end else begin
								emit_status = 1'b1;
							end
						end
						REQ_REGION: begin
							if (bid_ok && tid_ok) begin
								tbl_re    = 1'b1;
								tbl_raddr = block_id[AW-1:0];
								state_d   = S_CASE;
							end else begin
								emit        = 1'b1;
								emit_status = 1'b1;
							end
						end
						REQ_INCOMING: begin
							if (bid_ok) begin
								tbl_re    = 1'b1;
								tbl_raddr = '0;
								state_d   = S_SCAN;
							end else begin
								emit        = 1'b1;
								emit_status = 1'b1;
							end
						end
						default: begin
							emit        = 1'b1;
							emit_status = 1'b1;
						end
					endcase
				end
			end
			S_CASE: begin
				// case block needs both successors
				if (tbl_rdata_q.has_true && tbl_rdata_q.has_false) begin
					case_ok = 1'b1;
					phase_d = 1'b0;
					state_d = S_WINIT;
				end else begin
					emit        = 1'b1;
					emit_status = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_WINIT: begin
				vis_clr = 1'b1;
				sp_d    = '0;
				if (!start_ok) begin
					walk_done = 1'b1;
				end else if (start_q == tid_q) begin
					walk_done = 1'b1;
					walk_hit  = 1'b1;
				end else begin
					vis_set   = 1'b1;
					vis_idx   = start_q[AW-1:0];
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = start_q;
					sp_d      = SPW'(1);
					state_d   = S_POP;
				end
			end
			S_POP: begin
				if (sp_q == '0) begin
					walk_done = 1'b1;
				end else begin
					sp_d      = sp_m1;
					stk_re    = 1'b1;
					stk_raddr = sp_m1[AW-1:0];
					state_d   = S_POPW;
				end
			end
			S_POPW: begin
				tbl_re    = 1'b1;
				tbl_raddr = stk_rdata_q[AW-1:0];
				state_d   = S_EXP0;
			end
			S_EXP0, S_EXP1: begin
				state_d = (state_q == S_EXP0) ? S_EXP1 : S_POP;
				if (succ_ok) begin
					if (succ == tid_q) begin
						walk_done = 1'b1;
						walk_hit  = 1'b1;
					end else if (!visited_q[succ[AW-1:0]]) begin
						vis_set   = 1'b1;
						vis_idx   = succ[AW-1:0];
						stk_we    = 1'b1;
						stk_waddr = sp_q[AW-1:0];
						stk_wdata = succ;
						sp_d      = sp_q + SPW'(1);
					end
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					emit       = 1'b1;
					emit_found = 1'b1;
					emit_pred  = idx_q;
					emit_slot  = tbl_rdata_q.slot;
					state_d    = S_IDLE;
				end else if (scan_more) begin
					tbl_re    = 1'b1;
					tbl_raddr = idx_nxt[AW-1:0];
					scan_adv  = 1'b1;
				end else begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// end of a walk: start the false walk or report
		if (walk_done) begin
			if (!phase_q) begin
				phase_d = 1'b1;
				state_d = S_WINIT;
			end else begin
				emit          = 1'b1;
				emit_contains = rt_q && !walk_hit;
				state_d       = S_IDLE;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			phase_q   <= 1'b0;
			visited_q <= '0;
			done_q    <= 1'b0;
			n_q       <= 9'd1;
		end else begin
			state_q <= state_d;
			sp_q    <= sp_d;
			phase_q <= phase_d;
			done_q  <= emit;
			// a fresh walk keeps only its start block marked
			if (vis_clr) begin
				visited_q <= vis_set ? (DEPTH'(1) << vis_idx) : '0;
			end else if (vis_set) begin
				visited_q[vis_idx] <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				n_q <= (cfg_data < 9'(NCAP)) ? cfg_data : 9'(NCAP);
			end
		end
	end

	// Request operands, walk bookkeeping and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			bid_q <= block_id;
			tid_q <= target_blk;
			idx_q <= '0;
		end
		if (case_ok) begin
			start_q <= tbl_rdata_q.true_succ;
			fsucc_q <= tbl_rdata_q.false_succ;
		end
		if (walk_done && !phase_q) begin
			rt_q    <= walk_hit;
			start_q <= fsucc_q;
		end
		if (scan_adv) begin
			idx_q <= idx_nxt[7:0];
		end
		if (emit) begin
			status_q   <= emit_status;
			contains_q <= emit_contains;
			found_q    <= emit_found;
			pred_q     <= emit_pred;
			slot_q     <= emit_slot;
		end
	end

	// Block table memory
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (tbl_re) begin
			tbl_rdata_q <= tbl_mem[tbl_raddr];
		end
	end

	// Walk stack memory
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rdata_q <= stk_mem[stk_raddr];
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign region_contains = contains_q;
	assign found           = found_q;
	assign pred_block      = pred_q;
	assign branch_slot     = slot_q;

	// Checks
	`CBRR_ASSERT_NEXT(a_load_done, accept && (req_type == REQ_LOAD), done && !busy, "load beat gave no result")
	`CBRR_ASSERT_IMP(a_done_cause, done, $past(busy) || $past(start), "result without a request")
	`CBRR_ASSERT_IMP(a_exp_order, state_q == S_EXP0, $past(state_q == S_POPW), "edge scan without table read")
	`CBRR_ASSERT_NOW(a_sp_bound, sp_q <= SPW'(DEPTH), "walk stack overflow")
	`CBRR_ASSERT_IMP(a_result_excl, done && region_contains, !status && !found, "inconsistent region result")

endmodule
